>>> rtl/cwt_pkg.sv
package cwt_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_WINDOW_ORIGIN_X = 3'd2,
      CSR_WINDOW_ORIGIN_Y = 3'd3,
      CSR_WINDOW_WIDTH    = 3'd4,
      CSR_WINDOW_HEIGHT   = 3'd5,
      CSR_GRID_PERIOD     = 3'd6
   } cwt_csr_index_type;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [11:0] window_origin_x;
      logic [11:0] window_origin_y;
      logic [12:0] window_width;
      logic [12:0] window_height;
      logic [11:0] grid_period;
   } cwt_config_type;

   localparam logic [12:0] RESET_IMAGE_WIDTH     = 13'd640;
   localparam logic [12:0] RESET_IMAGE_HEIGHT    = 13'd480;
   localparam logic [11:0] RESET_WINDOW_ORIGIN_X = 12'd0;
   localparam logic [11:0] RESET_WINDOW_ORIGIN_Y = 12'd0;
   localparam logic [12:0] RESET_WINDOW_WIDTH    = 13'd640;
   localparam logic [12:0] RESET_WINDOW_HEIGHT   = 13'd480;
   localparam logic [11:0] RESET_GRID_PERIOD     = 12'd75;

   // gray level on grid lines
   localparam logic [7:0] GRID_GRAY = 8'd128;

   // red: r + floor(r*7/40), valid while r*47 < 10240
   localparam logic [7:0]  RED_LIMIT = 8'd218;
   localparam logic [13:0] RED_RECIP = 14'd11469;
   localparam int          RED_SHIFT = 16;

   // green: g + floor(g*71/1000), valid while g*1071 < 256000
   localparam logic [7:0]  GREEN_LIMIT = 8'd240;
   localparam logic [16:0] GREEN_RECIP = 17'd74449;
   localparam int          GREEN_SHIFT = 20;

   // depth of each queue
   localparam int QUEUE_DEPTH = 2;

   // classified pixel between front and back
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [5:0] noise;
      logic       gray;
      logic       last;
   } cwt_pixel_type;

   // finished result
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } cwt_result_type;

   function automatic logic [7:0] tint_red(input logic [7:0] r);
      logic [23:0] prod;
      logic [8:0]  sum;
      prod = 24'(r) * 24'(RED_RECIP);
      sum  = 9'(r) + 9'(prod >> RED_SHIFT);
      return (r < RED_LIMIT) ? sum[7:0] : r;
   endfunction

   function automatic logic [7:0] tint_green(input logic [7:0] g);
      logic [24:0] prod;
      logic [8:0]  sum;
      prod = 25'(g) * 25'(GREEN_RECIP);
      sum  = 9'(g) + 9'(prod >> GREEN_SHIFT);
      return (g < GREEN_LIMIT) ? sum[7:0] : g;
   endfunction

   function automatic logic [7:0] tint_blue(input logic [7:0] b, input logic [5:0] nz);
      logic [9:0] triple;
      logic [8:0] sum;
      triple = 10'(b) * 10'd3;
      sum    = 9'(nz) + 9'(triple >> 2);
      return sum[7:0];
   endfunction

endpackage

>>> rtl/crop_window_grid_tint_filter.sv
// crop window with diagonal gray grid and colour tint
//
// input queue: present a pixel and raise req_push; it is taken at a clock
// edge where req_full is low. req_frame_start marks the first pixel of a frame.
// only pixels inside the crop window make a result; others are dropped.
// result queue: while rsp_empty is low the oldest result sits on rsp_*;
// raise rsp_pop to take it. rsp_window_last flags the window's last pixel.
// csr port: csr_ready is always high, a write lands when csr_valid is high.
//
// flow: a kept pixel is classified by the front and written into the pixel
// queue at the edge that takes it; the back tints it into the result queue
// once that has room, and the head of the result queue drives the result ports.
// throughput: one pixel per cycle while req_full is low, set by the front
// classifier and the single tint stage; both queues are two deep.
// when the receiver stalls the result queue fills, then the pixel queue,
// then req_full rises; nothing is lost.
// reset: queues empty, raster position and grid phases zero, registers
// return to 640x480 image and window at origin 0,0, grid period 75.
module crop_window_grid_tint_filter import cwt_pkg::*; #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_red_in,
   input  logic [7:0]             req_green_in,
   input  logic [7:0]             req_blue_in,
   input  logic [7:0]             req_alpha_in,
   input  logic [5:0]             req_noise,
   input  logic                   req_frame_start,
   // result output
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_red_out,
   output logic [7:0]             rsp_green_out,
   output logic [7:0]             rsp_blue_out,
   output logic [7:0]             rsp_alpha_out,
   output logic                   rsp_window_last,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cwt_config_type cfg_ff, cfg_in;

   logic           accept;
   logic           kept_push;
   cwt_pixel_type  kept_pixel;
   logic           mid_full, mid_empty, mid_pop;
   logic [$bits(cwt_pixel_type)-1:0] mid_data;
   cwt_pixel_type  mid_pixel;
   logic           res_full, res_push;
   cwt_result_type res_in;
   logic [$bits(cwt_result_type)-1:0] res_data;
   cwt_result_type res_out;

   // register file, writes always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (cwt_csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_data;
            CSR_IMAGE_HEIGHT:    cfg_in.image_height    = csr_data;
            CSR_WINDOW_ORIGIN_X: cfg_in.window_origin_x = csr_data[11:0];
            CSR_WINDOW_ORIGIN_Y: cfg_in.window_origin_y = csr_data[11:0];
            CSR_WINDOW_WIDTH:    cfg_in.window_width    = csr_data;
            CSR_WINDOW_HEIGHT:   cfg_in.window_height   = csr_data;
            CSR_GRID_PERIOD:     cfg_in.grid_period     = csr_data[11:0];
            default:             cfg_in = cfg_ff;  // unused index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= RESET_IMAGE_WIDTH;
         cfg_ff.image_height    <= RESET_IMAGE_HEIGHT;
         cfg_ff.window_origin_x <= RESET_WINDOW_ORIGIN_X;
         cfg_ff.window_origin_y <= RESET_WINDOW_ORIGIN_Y;
         cfg_ff.window_width    <= RESET_WINDOW_WIDTH;
         cfg_ff.window_height   <= RESET_WINDOW_HEIGHT;
         cfg_ff.grid_period     <= RESET_GRID_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input is held off whenever the pixel queue is full
   assign req_full = mid_full;
   assign accept   = req_push && !req_full;

   // front: raster tracking, window test, grid classification
   cwt_front #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .red_in      (req_red_in),
      .green_in    (req_green_in),
      .blue_in     (req_blue_in),
      .alpha_in    (req_alpha_in),
      .noise       (req_noise),
      .frame_start (req_frame_start),
      .kept_push   (kept_push),
      .kept_pixel  (kept_pixel)
   );

   // queue of kept pixels between front and back
   cwt_fifo #(
      .WIDTH($bits(cwt_pixel_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (kept_push),
      .wr_data (kept_pixel),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_data),
      .empty   (mid_empty)
   );

   assign mid_pixel = cwt_pixel_type'(mid_data);

   // back: gray or tint arithmetic
   cwt_back u_back (
      .pixel_valid (!mid_empty),
      .pixel       (mid_pixel),
      .pixel_pop   (mid_pop),
      .result_full (res_full),
      .result_push (res_push),
      .result      (res_in)
   );

   // result queue, its head drives the output ports
   cwt_fifo #(
      .WIDTH($bits(cwt_result_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_in),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_data),
      .empty   (rsp_empty)
   );

   assign res_out         = cwt_result_type'(res_data);
   assign rsp_red_out     = res_out.red;
   assign rsp_green_out   = res_out.green;
   assign rsp_blue_out    = res_out.blue;
   assign rsp_alpha_out   = res_out.alpha;
   assign rsp_window_last = res_out.last;

endmodule

>>> rtl/cwt_fifo.sv
module cwt_fifo import cwt_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/cwt_front.sv
module cwt_front import cwt_pkg::*; #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic           clock,
   input  logic           reset,
   input  cwt_config_type cfg,
   input  logic           accept,
   input  logic [7:0]     red_in,
   input  logic [7:0]     green_in,
   input  logic [7:0]     blue_in,
   input  logic [7:0]     alpha_in,
   input  logic [5:0]     noise,
   input  logic           frame_start,
   output logic           kept_push,
   output cwt_pixel_type  kept_pixel
);

   localparam int DIM_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
   localparam int CW    = (DIM_W + 1 > 14) ? DIM_W + 1 : 14;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_DIMENSION);

   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [11:0]      cph_ff, cph_in, rph_ff, rph_in;

   logic [DIM_W-1:0] col, row;
   logic [11:0]      cph, rph, period;
   logic [CW-1:0]    iw, ih, col_end, row_end, ox_end, oy_end;
   logic [CW-1:0]    col_next, row_next;
   logic [12:0]      cph_step, rph_step;
   logic             kept, gray, last_col;

   always_comb begin
      iw = (cfg.image_width == '0) ? CW'(1) :
           (CW'(cfg.image_width) > MAX_C) ? MAX_C : CW'(cfg.image_width);
      ih = (cfg.image_height == '0) ? CW'(1) :
           (CW'(cfg.image_height) > MAX_C) ? MAX_C : CW'(cfg.image_height);
      period  = (cfg.grid_period == '0) ? 12'd1 : cfg.grid_period;
      ox_end  = CW'(cfg.window_origin_x) + CW'(cfg.window_width);
      oy_end  = CW'(cfg.window_origin_y) + CW'(cfg.window_height);
      col_end = (ox_end < iw) ? ox_end : iw;
      row_end = (oy_end < ih) ? oy_end : ih;

      // a frame start puts this pixel at the origin
      col = frame_start ? '0 : col_ff;
      row = frame_start ? '0 : row_ff;
      cph = frame_start ? '0 : cph_ff;
      rph = frame_start ? '0 : rph_ff;

      col_next = CW'(col) + CW'(1);
      row_next = CW'(row) + CW'(1);

      kept = (CW'(col) >= CW'(cfg.window_origin_x)) && (CW'(col) < col_end) &&
             (CW'(row) >= CW'(cfg.window_origin_y)) && (CW'(row) < row_end);
      gray = (cph == rph) || ((13'(cph) + 13'(rph)) == 13'(period));
      last_col = (col_next == col_end);

      cph_step = 13'(cph) + 13'd1;
      rph_step = 13'(rph) + 13'd1;

      cph_in = cph;
      rph_in = rph;
      if (kept) begin
         if (last_col) begin
            cph_in = '0;
            rph_in = (rph_step >= 13'(period)) ? '0 : rph_step[11:0];
         end else begin
            cph_in = (cph_step >= 13'(period)) ? '0 : cph_step[11:0];
         end
      end

      // raster advance, full image wrap restarts the grid
      col_in = col_next[DIM_W-1:0];
      row_in = row;
      if (col_next >= iw) begin
         col_in = '0;
         if (row_next >= ih) begin
            row_in = '0;
            cph_in = '0;
            rph_in = '0;
         end else begin
            row_in = row_next[DIM_W-1:0];
         end
      end

      kept_push        = accept && kept;
      kept_pixel.red   = red_in;
      kept_pixel.green = green_in;
      kept_pixel.blue  = blue_in;
      kept_pixel.alpha = alpha_in;
      kept_pixel.noise = noise;
      kept_pixel.gray  = gray;
      kept_pixel.last  = last_col && (row_next == row_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
      end
   end

endmodule

>>> rtl/cwt_back.sv
module cwt_back import cwt_pkg::*; (
   input  logic           pixel_valid,
   input  cwt_pixel_type  pixel,
   output logic           pixel_pop,
   input  logic           result_full,
   output logic           result_push,
   output cwt_result_type result
);

   assign pixel_pop   = pixel_valid && !result_full;
   assign result_push = pixel_pop;

   always_comb begin
      if (pixel.gray) begin
         result.red   = GRID_GRAY;
         result.green = GRID_GRAY;
         result.blue  = GRID_GRAY;
      end else begin
         result.red   = tint_red(pixel.red);
         result.green = tint_green(pixel.green);
         result.blue  = tint_blue(pixel.blue, pixel.noise);
      end
      result.alpha = pixel.alpha;
      result.last  = pixel.last;
   end

endmodule

>>> rtl/cwt_checker.sv
module cwt_checker import cwt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input logic [7:0]             rsp_red_out,
   input logic [7:0]             rsp_green_out,
   input logic [7:0]             rsp_blue_out,
   input logic [7:0]             rsp_alpha_out,
   input logic                   rsp_window_last,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index
);

   // reset leaves the result queue empty and the pixel queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_red_out) &&
         $stable(rsp_green_out) && $stable(rsp_blue_out) &&
         $stable(rsp_alpha_out) && $stable(rsp_window_last))
      else $error("result changed while stalled");

   // blue is at most 63 + 191, or gray
   a_blue_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_blue_out != 8'hFF)
      else $error("blue out of range");

   // register port never back-pressures, checked on image width and grid period writes
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_GRID_PERIOD)
      |-> csr_ready)
      else $error("register write refused");

endmodule

bind crop_window_grid_tint_filter cwt_checker u_checker (.*);

>>> verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cwt_pkg::*;

   // raster geometry is clamped to this many pixels per side
   localparam int unsigned SIZE_LIMIT   = 4096;
   // cycles to let the pipe settle after the last expected pixel
   localparam int          DRAIN_CYCLES = 8;
   // random pixels after the directed frame
   localparam int          RANDOM_ITEMS = 1300;
   // longest frame pushed in one go for the small random geometries
   localparam int unsigned FRAME_CAP    = 160;
   // idle chance per cycle, in percent
   localparam int          IDLE_PERCENT = 32;

   // one source pixel as pushed into the block
   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [5:0] noise;
      logic       frame_start;
   } pixel_item_type;

   // channel extremes and the tint saturation edges
   localparam logic [7:0] EDGE_VALUES [10] = '{
      8'd0, 8'd255, 8'd217, 8'd218, 8'd239, 8'd240, 8'd1, 8'd127, 8'd128, 8'd254
   };

   // crop / grid / tint predictor plus the queue of pixels it expects
   class pixel_scoreboard;
      logic [12:0] image_width, image_height, window_width, window_height;
      logic [11:0] origin_x, origin_y, grid_period;
      int unsigned column, row, column_phase, row_phase;
      cwt_result_type expected_q[$];
      int errors;

      function new();
         image_width   = RESET_IMAGE_WIDTH;
         image_height  = RESET_IMAGE_HEIGHT;
         origin_x      = RESET_WINDOW_ORIGIN_X;
         origin_y      = RESET_WINDOW_ORIGIN_Y;
         window_width  = RESET_WINDOW_WIDTH;
         window_height = RESET_WINDOW_HEIGHT;
         grid_period   = RESET_GRID_PERIOD;
         column        = 0;
         row           = 0;
         column_phase  = 0;
         row_phase     = 0;
         errors        = 0;
      endfunction

      function void set_reg(cwt_csr_index_type idx, logic [12:0] value);
         case (idx)
            CSR_IMAGE_WIDTH:     image_width   = value;
            CSR_IMAGE_HEIGHT:    image_height  = value;
            CSR_WINDOW_ORIGIN_X: origin_x      = value[11:0];
            CSR_WINDOW_ORIGIN_Y: origin_y      = value[11:0];
            CSR_WINDOW_WIDTH:    window_width  = value;
            CSR_WINDOW_HEIGHT:   window_height = value;
            CSR_GRID_PERIOD:     grid_period   = value[11:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_size(int unsigned v);
         if (v == 0) return 1;
         if (v > SIZE_LIMIT) return SIZE_LIMIT;
         return v;
      endfunction

      function int unsigned advance(int unsigned ph, int unsigned p);
         return (ph + 1 >= p) ? 0 : ph + 1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // called for every pixel the block takes
      function void note_pixel(pixel_item_type px);
         int unsigned iw, ih, period, col_end, row_end, red_t, green_t, blue_t;
         bit kept, last_col;
         cwt_result_type res;
         iw      = clamp_size(image_width);
         ih      = clamp_size(image_height);
         period  = (grid_period == 0) ? 1 : grid_period;
         col_end = int'(origin_x) + int'(window_width);
         if (col_end > iw) col_end = iw;
         row_end = int'(origin_y) + int'(window_height);
         if (row_end > ih) row_end = ih;

         if (px.frame_start) begin
            column       = 0;
            row          = 0;
            column_phase = 0;
            row_phase    = 0;
         end

         kept = column >= origin_x && column < col_end && row >= origin_y && row < row_end;
         if (kept) begin
            last_col = (column + 1 == col_end);
            if (column_phase == row_phase || column_phase + row_phase == period) begin
               res.red   = GRID_GRAY;
               res.green = GRID_GRAY;
               res.blue  = GRID_GRAY;
            end else begin
               // x1.175 and x1.071, left alone where they would pass 255
               red_t     = int'(px.red) * 47;
               green_t   = int'(px.green) * 1071;
               blue_t    = int'(px.noise) + ((int'(px.blue) * 3) >> 2);
               res.red   = (red_t < 10240) ? 8'(red_t / 40) : px.red;
               res.green = (green_t < 256000) ? 8'(green_t / 1000) : px.green;
               res.blue  = 8'(blue_t);
            end
            res.alpha = px.alpha;
            res.last  = last_col && (row + 1 == row_end);
            expected_q.push_back(res);
            if (last_col) begin
               column_phase = 0;
               row_phase    = advance(row_phase, period);
            end else begin
               column_phase = advance(column_phase, period);
            end
         end

         if (column + 1 >= iw) begin
            column = 0;
            if (row + 1 >= ih) begin
               row          = 0;
               column_phase = 0;
               row_phase    = 0;
            end else begin
               row = row + 1;
            end
         end else begin
            column = column + 1;
         end
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(cwt_result_type got);
         cwt_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("pixel out with nothing expected (red %0d)", got.red));
            return;
         end
         want = expected_q.pop_front();
         if (got.red !== want.red)
            report($sformatf("red_out got %0d want %0d", got.red, want.red));
         if (got.green !== want.green)
            report($sformatf("green_out got %0d want %0d", got.green, want.green));
         if (got.blue !== want.blue)
            report($sformatf("blue_out got %0d want %0d", got.blue, want.blue));
         if (got.alpha !== want.alpha)
            report($sformatf("alpha_out got %0d want %0d", got.alpha, want.alpha));
         if (got.last !== want.last)
            report($sformatf("window_last got %0b want %0b", got.last, want.last));
      endtask
   endclass

   // clock, reset and block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [7:0]             req_red_in = '0;
   logic [7:0]             req_green_in = '0;
   logic [7:0]             req_blue_in = '0;
   logic [7:0]             req_alpha_in = '0;
   logic [5:0]             req_noise = '0;
   logic                   req_frame_start = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [7:0]             rsp_red_out;
   logic [7:0]             rsp_green_out;
   logic [7:0]             rsp_blue_out;
   logic [7:0]             rsp_alpha_out;
   logic                   rsp_window_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // both sides stop idling while this is set
   bit steady = 1'b0;
   int sent_items = 0;

   pixel_scoreboard sb = new();

   crop_window_grid_tint_filter dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_alpha_in    (req_alpha_in),
      .req_noise       (req_noise),
      .req_frame_start (req_frame_start),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_alpha_out   (rsp_alpha_out),
      .rsp_window_last (rsp_window_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // result side: take a pixel on pop and not empty, then pick next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_result(cwt_result_type'{rsp_red_out, rsp_green_out, rsp_blue_out,
                                          rsp_alpha_out, rsp_window_last});
      rsp_pop <= reset ? 1'b0 : (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // push one pixel, with random idle cycles in front of it
   task automatic send_pixel(pixel_item_type px);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_red_in      <= px.red;
      req_green_in    <= px.green;
      req_blue_in     <= px.blue;
      req_alpha_in    <= px.alpha;
      req_noise       <= px.noise;
      req_frame_start <= px.frame_start;
      // taken at the first edge where full is low
      do @(posedge clock); while (req_full);
      sb.note_pixel(px);
      sent_items++;
   endtask

   // stop pushing until every expected pixel is out, then let the pipe empty
   task automatic wait_until_idle();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(cwt_csr_index_type idx, logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, value);
   endtask

   // registers only change once the block has gone quiet
   task automatic write_settings(cwt_config_type c);
      wait_until_idle();
      write_reg(CSR_IMAGE_WIDTH, c.image_width);
      write_reg(CSR_IMAGE_HEIGHT, c.image_height);
      write_reg(CSR_WINDOW_ORIGIN_X, 13'(c.window_origin_x));
      write_reg(CSR_WINDOW_ORIGIN_Y, 13'(c.window_origin_y));
      write_reg(CSR_WINDOW_WIDTH, c.window_width);
      write_reg(CSR_WINDOW_HEIGHT, c.window_height);
      write_reg(CSR_GRID_PERIOD, 13'(c.grid_period));
      csr_valid <= 1'b0;
   endtask

   function automatic pixel_item_type random_pixel();
      pixel_item_type px;
      px.red         = 8'($urandom);
      px.green       = 8'($urandom);
      px.blue        = 8'($urandom);
      px.alpha       = 8'($urandom);
      px.noise       = 6'($urandom);
      px.frame_start = 1'b0;
      return px;
   endfunction

   // directed pixel k: cycles through the channel edges, noise at 0 and 63
   function automatic pixel_item_type edge_pixel(int k);
      pixel_item_type px;
      px.red         = EDGE_VALUES[k % 10];
      px.green       = EDGE_VALUES[(k + 3) % 10];
      px.blue        = EDGE_VALUES[(k + 7) % 10];
      px.alpha       = EDGE_VALUES[(k + 5) % 10];
      px.noise       = k[0] ? 6'd63 : 6'd0;
      px.frame_start = (k == 0);
      return px;
   endfunction

   // mostly small rasters so frames complete; now and then any register value
   function automatic cwt_config_type random_settings();
      cwt_config_type c;
      int unsigned iw, ih;
      if ($urandom_range(0, 9) == 0) begin
         c.image_width     = 13'($urandom);
         c.image_height    = 13'($urandom);
         c.window_origin_x = 12'($urandom);
         c.window_origin_y = 12'($urandom);
         c.window_width    = 13'($urandom);
         c.window_height   = 13'($urandom);
         c.grid_period     = 12'($urandom);
      end else begin
         iw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
         ih = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
         c.image_width     = 13'(iw);
         c.image_height    = 13'(ih);
         // origin can sit past the edge, giving an empty window
         c.window_origin_x = 12'($urandom_range(0, iw + 1));
         c.window_origin_y = 12'($urandom_range(0, ih));
         c.window_width    = 13'($urandom_range(0, iw + 2));
         c.window_height   = ($urandom_range(0, 9) == 0) ? 13'h1fff
                                                         : 13'($urandom_range(0, ih + 3));
         c.grid_period     = ($urandom_range(0, 9) == 0) ? 12'hfff
                                                         : 12'($urandom_range(0, 7));
      end
      return c;
   endfunction

   // pixels in one full frame, held to a small number
   function automatic int unsigned frame_pixels(cwt_config_type c);
      int unsigned w, h;
      w = (c.image_width == 0) ? 1 : c.image_width;
      h = (c.image_height == 0) ? 1 : c.image_height;
      return (w * h > FRAME_CAP) ? FRAME_CAP : w * h;
   endfunction

   // stimulus
   initial begin
      cwt_config_type cfg;
      pixel_item_type px;
      int unsigned    len;
      int             frames, phase;
      bit             carry_on;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a couple of pixels on the reset geometry
      for (int k = 0; k < 2; k++) send_pixel(edge_pixel(k));

      // directed frame: 12x2 image, window from column 1 clipped to 2 rows,
      // period 5 so both diagonals show up
      cfg = '{image_width: 13'd12, image_height: 13'd2, window_origin_x: 12'd1,
              window_origin_y: 12'd0, window_width: 13'd10, window_height: 13'd5,
              grid_period: 12'd5};
      write_settings(cfg);
      for (int k = 0; k < 24; k++) send_pixel(edge_pixel(k));

      sent_items = 0;
      phase      = 0;
      while (sent_items < RANDOM_ITEMS) begin
         case (phase)
            // zero sizes and zero period: every pixel kept, gray and last
            0: cfg = '{image_width: 13'd0, image_height: 13'd0, window_origin_x: 12'd0,
                       window_origin_y: 12'd0, window_width: 13'd1, window_height: 13'd1,
                       grid_period: 12'd0};
            // wide raster at the size limit, long kept row
            1: cfg = '{image_width: 13'd4096, image_height: 13'd2, window_origin_x: 12'd0,
                       window_origin_y: 12'd0, window_width: 13'h1fff, window_height: 13'd1,
                       grid_period: 12'hfff};
            // every register at its top value
            2: cfg = '{image_width: 13'h1fff, image_height: 13'h1fff,
                       window_origin_x: 12'hfff, window_origin_y: 12'hfff,
                       window_width: 13'h1fff, window_height: 13'h1fff,
                       grid_period: 12'hfff};
            default: cfg = random_settings();
         endcase
         write_settings(cfg);
         steady = (phase == 4 || phase == 5);

         frames   = $urandom_range(1, 3);
         // sometimes keep the raster going across the register change
         carry_on = ($urandom_range(0, 3) == 0);
         for (int f = 0; f < frames; f++) begin
            case (phase)
               0:       len = 20;
               1:       len = 300;
               2:       len = 40;
               default: len = frame_pixels(cfg);
            endcase
            // broken frame: cut short
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
            for (int unsigned k = 0; k < len; k++) begin
               px             = random_pixel();
               px.frame_start = (k == 0) && !(f == 0 && carry_on);
               // stray or missing frame marks
               if ($urandom_range(0, 49) == 0) px.frame_start = ~px.frame_start;
               send_pixel(px);
               // sender holds off until the result side has caught up
               if ($urandom_range(0, 199) == 0) wait_until_idle();
            end
         end
         phase++;
      end
      steady = 1'b0;

      wait_until_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** crop_window_grid_tint_filter: PASSED **");
      end else begin
         $display("** crop_window_grid_tint_filter: FAILED **");
      end
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("** crop_window_grid_tint_filter: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
rtl/cwt_pkg.sv
rtl/cwt_fifo.sv
rtl/cwt_front.sv
rtl/cwt_back.sv
rtl/crop_window_grid_tint_filter.sv
rtl/cwt_checker.sv
verif/testbench.sv
